// ----- src/u16p_pkg.sv -----
// Shared types, character codes and decode helpers for the UTF-16 integer parser.
// No dependencies; imported by u16p_step and utf16_string_to_integer_parser_core.
package u16p_pkg;

  localparam int VALUE_BITS_DEFAULT = 64;
  localparam int MAX_LEN_DEFAULT    = 1024;
  localparam int VALUE_OUT_W        = 64;
  localparam int COUNT_W            = 11;
  localparam int BASE_W             = 6;

  localparam logic [BASE_W-1:0] NUMBER_BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_OCT          = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC          = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX          = 6'd16;
  localparam logic [BASE_W-1:0] BASE_AUTO         = 6'd0;
  localparam logic [BASE_W-1:0] DIGIT_NONE        = 6'd63;

  localparam logic [15:0] CH_MINUS   = 16'h002D;
  localparam logic [15:0] CH_PLUS    = 16'h002B;
  localparam logic [15:0] CH_ZERO    = 16'h0030;
  localparam logic [15:0] CH_NINE    = 16'h0039;
  localparam logic [15:0] CH_LOWER_X = 16'h0078;
  localparam logic [15:0] CH_UPPER_X = 16'h0058;
  localparam logic [15:0] CH_UPPER_A = 16'h0041;
  localparam logic [15:0] CH_UPPER_Z = 16'h005A;
  localparam logic [15:0] CH_LOWER_A = 16'h0061;
  localparam logic [15:0] CH_LOWER_Z = 16'h007A;

  // parse phases
  localparam logic [2:0] PH_WS     = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_X      = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_last;
  } u16p_unit_t;

  typedef struct packed {
    logic signed [VALUE_OUT_W-1:0] parsed_value;
    logic                          overflow;
    logic [COUNT_W-1:0]            consumed_count;
  } u16p_result_t;

  typedef struct packed {
    logic [2:0]        parse_phase;
    logic              negative_sign;
    logic              overflow_seen;
    logic              digit_seen;
    logic [BASE_W-1:0] active_base;
  } u16p_ctl_t;

  localparam u16p_ctl_t CTL_RESET = '{
    parse_phase:   PH_WS,
    negative_sign: 1'b0,
    overflow_seen: 1'b0,
    digit_seen:    1'b0,
    active_base:   BASE_DEC
  };

  function automatic logic is_space(input logic [15:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      [16'h0009:16'h000D], [16'h001C:16'h0020], 16'h0085, 16'h00A0, 16'h1680,
      [16'h2000:16'h200A], 16'h2028, 16'h2029, 16'h202F, 16'h205F,
      16'h3000: r = 1'b1;
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

  // digit value 0..35, DIGIT_NONE for anything else
  function automatic logic [BASE_W-1:0] digit_value(input logic [15:0] c);
    logic [15:0] t;
    t = {10'd0, DIGIT_NONE};
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      t = c - CH_UPPER_A + 16'd10;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      t = c - CH_LOWER_A + 16'd10;
    end
    return t[BASE_W-1:0];
  endfunction

endpackage

// ----- src/u16p_step.sv -----
// Next-state logic for one code unit: phase decode plus one shared multiply-add
// with saturation check. Depends on u16p_pkg.
module u16p_step #(
  parameter int VALUE_BITS = u16p_pkg::VALUE_BITS_DEFAULT,
  parameter int MAX_LEN    = u16p_pkg::MAX_LEN_DEFAULT,
  localparam int POS_W     = $clog2(MAX_LEN + 1)
) (
  input  logic [u16p_pkg::BASE_W-1:0] number_base,
  input  u16p_pkg::u16p_unit_t        unit,
  input  u16p_pkg::u16p_ctl_t         ctl,
  input  logic [VALUE_BITS-1:0]       acc,
  input  logic [POS_W-1:0]            pos,
  input  logic [POS_W-1:0]            end_pos,
  output u16p_pkg::u16p_ctl_t         ctl_next,
  output logic [VALUE_BITS-1:0]       acc_next,
  output logic [POS_W-1:0]            pos_next,
  output logic [POS_W-1:0]            end_pos_next
);
  import u16p_pkg::*;

  localparam int PW = VALUE_BITS + BASE_W;
  localparam logic [PW-1:0] LIMIT_POS = PW'({1'b0, {(VALUE_BITS-1){1'b1}}});
  localparam logic [PW-1:0] LIMIT_NEG = PW'({1'b1, {(VALUE_BITS-1){1'b0}}});

  logic [15:0]       c;
  logic [BASE_W-1:0] d;
  logic [BASE_W-1:0] base_in;
  logic [BASE_W-1:0] feed_base;
  logic              feed;
  logic              first;
  logic              digit_ok;
  logic [PW-1:0]     prod;
  logic [PW-1:0]     limit;
  logic              over;

  assign c        = unit.code_unit;
  assign d        = digit_value(c);
  assign base_in  = (pos == '0) ? number_base : ctl.active_base;
  assign pos_next = (pos < POS_W'(MAX_LEN)) ? pos + 1'b1 : pos;

  assign digit_ok = (feed_base != BASE_AUTO) && (d < feed_base);
  assign prod     = PW'(acc) * PW'(feed_base) + PW'(d);
  assign limit    = ctl.negative_sign ? LIMIT_NEG : LIMIT_POS;
  assign over     = ctl.overflow_seen || (prod > limit);

  always_comb begin
    ctl_next             = ctl;
    ctl_next.active_base = base_in;
    acc_next             = acc;
    end_pos_next         = end_pos;
    feed                 = 1'b0;
    first                = 1'b0;
    feed_base            = base_in;

    unique case (ctl.parse_phase)
      PH_WS: begin
        if (!is_space(c)) begin
          if (c == CH_MINUS || c == CH_PLUS) begin
            ctl_next.negative_sign = (c == CH_MINUS);
            ctl_next.parse_phase   = PH_SIGN;
          end else begin
            first = 1'b1;
          end
        end
      end
      PH_SIGN: begin
        first = 1'b1;
      end
      PH_ZERO: begin
        if (c == CH_LOWER_X || c == CH_UPPER_X) begin
          ctl_next.parse_phase = PH_X;
        end else begin
          feed_base           = (base_in == BASE_AUTO) ? BASE_OCT : base_in;
          ctl_next.digit_seen = 1'b1;
          feed                = 1'b1;
        end
      end
      PH_X: begin
        feed_base = BASE_HEX;
        feed      = 1'b1;
      end
      PH_DIGITS: begin
        feed = 1'b1;
      end
      default: begin
      end
    endcase

    // first significant unit: leading zero may open a prefix
    if (first) begin
      if ((base_in == BASE_AUTO || base_in == BASE_HEX) && c == CH_ZERO) begin
        ctl_next.parse_phase = PH_ZERO;
        end_pos_next         = pos_next;
      end else begin
        feed_base = (base_in == BASE_AUTO) ? BASE_DEC : base_in;
        feed      = 1'b1;
      end
    end

    if (feed) begin
      ctl_next.active_base = feed_base;
      if (digit_ok) begin
        ctl_next.parse_phase   = PH_DIGITS;
        ctl_next.overflow_seen = over;
        ctl_next.digit_seen    = 1'b1;
        acc_next               = over ? acc : prod[VALUE_BITS-1:0];
        end_pos_next           = pos_next;
      end else begin
        ctl_next.parse_phase = PH_DONE;
      end
    end
  end

endmodule

// ----- src/utf16_string_to_integer_parser_core.sv -----
// UTF-16 string to signed integer parser: top level with input register, parse
// state, result register and radix register. Depends on u16p_pkg and u16p_step.
// A unit is held in the input register and processed from there; the result of
//   the unit marked last is then written to the result register.
// Throughput: 1 code unit per cycle unless a last unit waits on a stalled
//   result, set by the accumulator loop (radix multiply-add, saturation compare).
// Reset (rst, synchronous): clears parse state, empties both registers and
//   sets number_base to 10.
module utf16_string_to_integer_parser_core #(
  parameter int VALUE_BITS = u16p_pkg::VALUE_BITS_DEFAULT,
  parameter int MAX_LEN    = u16p_pkg::MAX_LEN_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  // code unit channel
  input  logic                        unit_valid,
  output logic                        unit_stall,
  input  u16p_pkg::u16p_unit_t        unit_data,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output u16p_pkg::u16p_result_t      result_data,
  // radix register write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [u16p_pkg::BASE_W-1:0] cfg_data
);
  import u16p_pkg::*;

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // radix register; taken into the parse state on the first unit of a string
  logic [BASE_W-1:0] number_base;

  // input register
  logic       s1_valid;
  u16p_unit_t s1_item;

  // parse state
  u16p_ctl_t             ctl;
  logic [VALUE_BITS-1:0] acc;
  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      end_pos;

  u16p_ctl_t             ctl_next;
  logic [VALUE_BITS-1:0] acc_next;
  logic [POS_W-1:0]      pos_next;
  logic [POS_W-1:0]      end_pos_next;

  logic                  out_free;
  logic                  s1_go;
  logic                  s1_done;
  logic                  accept;
  logic                  ds_final;
  logic [VALUE_BITS-1:0] value_vb;
  u16p_result_t          result_next;

  // Only a last unit needs the result register; other units go straight through
  // even while a result waits to be taken.
  assign out_free   = !result_valid || !result_stall;
  assign s1_go      = s1_valid && (!s1_item.is_last || out_free);
  assign s1_done    = s1_go && s1_item.is_last;
  assign unit_stall = s1_valid && !s1_go;
  assign accept     = unit_valid && !unit_stall;
  assign cfg_ready  = 1'b1;

  u16p_step #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_LEN    (MAX_LEN)
  ) u_step (
    .number_base  (number_base),
    .unit         (s1_item),
    .ctl          (ctl),
    .acc          (acc),
    .pos          (pos),
    .end_pos      (end_pos),
    .ctl_next     (ctl_next),
    .acc_next     (acc_next),
    .pos_next     (pos_next),
    .end_pos_next (end_pos_next)
  );

  // Terminator after the last unit: it never adds a digit; a lone leading
  // zero still counts as a parsed digit.
  assign ds_final = ctl_next.digit_seen || (ctl_next.parse_phase == PH_ZERO);

  always_comb begin
    if (ctl_next.overflow_seen) begin
      value_vb = ctl_next.negative_sign ? VAL_MIN : VAL_MAX;
    end else begin
      value_vb = ctl_next.negative_sign ? (VALUE_BITS'(0) - acc_next) : acc_next;
    end
    result_next.parsed_value   = VALUE_OUT_W'(signed'(value_vb));
    result_next.overflow       = ctl_next.overflow_seen;
    result_next.consumed_count = ds_final ? COUNT_W'(end_pos_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= NUMBER_BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      number_base <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= unit_data;
    end
  end

  // parse state; cleared after each string
  always_ff @(posedge clk) begin
    if (rst || s1_done) begin
      ctl     <= CTL_RESET;
      acc     <= '0;
      pos     <= '0;
      end_pos <= '0;
    end else if (s1_go) begin
      ctl     <= ctl_next;
      acc     <= acc_next;
      pos     <= pos_next;
      end_pos <= end_pos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      result_data <= result_next;
    end
  end

  // saturated results carry exactly the min or max
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.overflow |->
      result_data.parsed_value == VALUE_OUT_W'(signed'(VAL_MAX)) ||
      result_data.parsed_value == VALUE_OUT_W'(signed'(VAL_MIN)))
    else $error("overflow result not saturated");

  // accumulator never exceeds the magnitude of the most negative value
  assert property (@(posedge clk) disable iff (rst)
    acc <= VAL_MIN)
    else $error("accumulator out of range");

  // a finished string restarts parsing and presents a result
  assert property (@(posedge clk) disable iff (rst)
    s1_done |=> pos == '0 && ctl.parse_phase == PH_WS && result_valid)
    else $error("parse state not cleared after result");

  // no digit parsed means a plain zero result
  assert property (@(posedge clk) disable iff (rst)
    s1_done && !ds_final |=>
      result_data.parsed_value == '0 && !result_data.overflow &&
      result_data.consumed_count == '0)
    else $error("empty parse gave nonzero result");

endmodule

// ----- tb/utf16_string_to_integer_parser_core_tb.sv -----
// Testbench for utf16_string_to_integer_parser_core: directed strings, then random strings
// checked against an in-bench strtol-style predictor. Depends on u16p_pkg and the core RTL.
`timescale 1ns / 100ps

module utf16_string_to_integer_parser_core_tb;
  import u16p_pkg::*;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          RAND_UNITS  = 550;
  localparam int          STR_CAP     = MAX_LEN_DEFAULT;
  localparam logic [63:0] S64_MIN     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int          N_DIR       = 25;

  typedef logic [15:0] units_t[$];

  // One directed string. base < 0 keeps the current radix; pad_len copies of pad_unit
  // go in front of the text. In the text, '_' is U+3000, '%' is U+2000, '|' is U+FFFF
  // and '$' is a NUL unit.
  typedef struct {
    int          base;
    int          pad_len;
    logic [15:0] pad_unit;
    string       text;
    bit          typed;
    logic [63:0] val;
    bit          ovf;
    int          cnt;
  } dir_row_t;

  // Hand-written result for a string, used in place of the prediction when on is set
  typedef struct {
    bit           on;
    u16p_result_t r;
  } answer_t;

  logic         clk;
  logic         rst          = 1'b1;
  logic         unit_valid   = 1'b0;
  logic         unit_stall;
  u16p_unit_t   unit_data    = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  u16p_result_t result_data;
  logic         cfg_valid    = 1'b0;
  logic         cfg_ready;
  logic [BASE_W-1:0] cfg_data = '0;

  utf16_string_to_integer_parser_core dut (
    .clk          (clk),
    .rst          (rst),
    .unit_valid   (unit_valid),
    .unit_stall   (unit_stall),
    .unit_data    (unit_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Directed strings: reset radix first, then value extremes, overflow,
  // prefix handling, radix 0/1/2/8/16/36/63, odd units and long strings.
  // ------------------------------------------------------------------
  dir_row_t dir_rows [N_DIR] = '{
    '{-1,    0, 16'h0000, "123",                   1, 64'd123,  0, 3},
    '{-1,    0, 16'h0000, "-9223372036854775808",  1, S64_MIN,  0, 20},
    '{-1,    0, 16'h0000, "9223372036854775807",   1, S64_MAX,  0, 19},
    '{-1,    0, 16'h0000, "9223372036854775808",   1, S64_MAX,  1, 19},
    '{-1,    0, 16'h0000, "-99999999999999999999", 1, S64_MIN,  1, 21},
    '{-1,    0, 16'h0000, " \t\n+42xyz",           1, 64'd42,   0, 6},
    '{-1,    0, 16'h0000, "abc",                   1, 64'd0,    0, 0},
    '{-1,    0, 16'h0000, "-",                     1, 64'd0,    0, 0},
    '{16,    0, 16'h0000, "0x",                    1, 64'd0,    0, 0},
    '{16,    0, 16'h0000, "0XfF",                  1, 64'd255,  0, 4},
    '{16,    0, 16'h0000, "-8000000000000000",     1, S64_MIN,  0, 17},
    '{16,    0, 16'h0000, "ffffffffffffffff",      1, S64_MAX,  1, 16},
    '{0,     0, 16'h0000, "0x1A",                  1, 64'd26,   0, 4},
    '{0,     0, 16'h0000, "017",                   1, 64'd15,   0, 3},
    '{0,     0, 16'h0000, "09",                    1, 64'd0,    0, 1},
    '{0,     0, 16'h0000, "+98$7",                 0, 64'd0,    0, 0},
    '{0,     0, 16'h0000, "0xg",                   1, 64'd0,    0, 0},
    '{36,    0, 16'h0000, "zZ",                    1, 64'd1295, 0, 2},
    '{36,    0, 16'h0000, "-ZZZZZZZZZZZZZZ",       0, 64'd0,    0, 0},
    '{2,     0, 16'h0000, "-1012",                 1, -64'sd5,  0, 4},
    '{1,     0, 16'h0000, "0001",                  0, 64'd0,    0, 0},
    '{63,    0, 16'h0000, "Zz9|",                  0, 64'd0,    0, 0},
    '{8,     0, 16'h0000, "_%12$3",                0, 64'd0,    0, 0},
    '{10, 1026, 16'h0030, "7",                     1, 64'd7,    0, 1024},
    '{10,   20, 16'h0020, "-5",                    1, -64'sd5,  0, 22}
  };

  logic [15:0] blank_units [21] = '{
    16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h001C, 16'h001D,
    16'h001E, 16'h001F, 16'h0020, 16'h0085, 16'h00A0, 16'h1680, 16'h2000,
    16'h2005, 16'h200A, 16'h2028, 16'h2029, 16'h202F, 16'h205F, 16'h3000
  };

  // ------------------------------------------------------------------
  // Predictor state: a private copy of the parse state and the radix reg
  // ------------------------------------------------------------------
  logic [2:0]        ph;
  logic [63:0]       acc;
  bit                neg;
  bit                ovf_f;
  bit                dig_f;
  logic [BASE_W-1:0] radix;
  logic [BASE_W-1:0] base_reg = NUMBER_BASE_RESET;
  int                pos;
  int                end_pos;

  u16p_result_t pending_parses[$];   // parses still owed by the block, oldest first
  answer_t      answer_key[$];       // one entry per string, in send order
  u16p_result_t predicted;
  u16p_result_t want;
  answer_t      key;

  int mismatches  = 0;
  int cycle_count = 0;
  bit quiet       = 1'b0;            // no idling on either side near the end

  function automatic int bump(input int p);
    return (p < STR_CAP) ? p + 1 : STR_CAP;
  endfunction

  function automatic bit is_blank(input logic [15:0] c);
    return (c >= 16'h0009 && c <= 16'h000D) || (c >= 16'h001C && c <= 16'h0020) ||
           c == 16'h0085 || c == 16'h00A0 || c == 16'h1680 ||
           (c >= 16'h2000 && c <= 16'h200A) || c == 16'h2028 || c == 16'h2029 ||
           c == 16'h202F || c == 16'h205F || c == 16'h3000;
  endfunction

  // 0..35 for a digit, 255 for anything else
  function automatic int digit_of(input logic [15:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return int'(c - CH_UPPER_A) + 10;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return int'(c - CH_LOWER_A) + 10;
    return 255;
  endfunction

  function automatic logic [15:0] char_of(input int v, input bit up);
    return (v < 10) ? CH_ZERO + 16'(v) : (up ? CH_UPPER_A : CH_LOWER_A) + 16'(v - 10);
  endfunction

  function automatic void restart();
    ph      = PH_WS;
    acc     = '0;
    neg     = 1'b0;
    ovf_f   = 1'b0;
    dig_f   = 1'b0;
    radix   = BASE_DEC;
    pos     = 0;
    end_pos = 0;
  endfunction

  // Multiply-add with saturation; the limit is one larger for negative numbers
  function automatic void take_digit(input logic [15:0] c, input int p);
    int          d;
    logic [63:0] lim;
    logic [63:0] cut;
    logic [63:0] cutl;
    d = digit_of(c);
    if (radix == BASE_AUTO || d >= int'(radix)) begin
      ph = PH_DONE;
      return;
    end
    ph   = PH_DIGITS;
    lim  = neg ? S64_MIN : S64_MAX;
    cut  = lim / radix;
    cutl = lim % radix;
    if (ovf_f || acc > cut || (acc == cut && 64'(d) > cutl)) begin
      ovf_f = 1'b1;
    end else begin
      acc = acc * radix + 64'(d);
    end
    dig_f   = 1'b1;
    end_pos = bump(p);
  endfunction

  // First unit after whitespace/sign: a '0' may open a prefix in radix 0 or 16
  function automatic void lead_digit(input logic [15:0] c, input int p);
    if ((radix == BASE_AUTO || radix == BASE_HEX) && c == CH_ZERO) begin
      ph      = PH_ZERO;
      end_pos = bump(p);
      return;
    end
    if (radix == BASE_AUTO) radix = BASE_DEC;
    take_digit(c, p);
  endfunction

  function automatic void scan(input logic [15:0] c, input int p);
    case (ph)
      PH_WS: begin
        if (!is_blank(c)) begin
          if (c == CH_MINUS || c == CH_PLUS) begin
            neg = (c == CH_MINUS);
            ph  = PH_SIGN;
          end else begin
            lead_digit(c, p);
          end
        end
      end
      PH_SIGN: lead_digit(c, p);
      PH_ZERO: begin
        if (c == CH_LOWER_X || c == CH_UPPER_X) begin
          ph = PH_X;
        end else begin
          if (radix == BASE_AUTO) radix = BASE_OCT;
          dig_f = 1'b1;
          ph    = PH_DIGITS;
          take_digit(c, p);
        end
      end
      PH_X: begin
        radix = BASE_HEX;
        take_digit(c, p);
      end
      PH_DIGITS: take_digit(c, p);
      default: ;
    endcase
  endfunction

  // Feeds one accepted unit; returns 1 with the parse result on the last unit
  function automatic bit parse_unit(input u16p_unit_t u, output u16p_result_t res);
    int p;
    p = pos;
    res = '0;
    if (p == 0) radix = base_reg;   // radix is latched per string
    pos = bump(p);
    scan(u.code_unit, p);
    if (!u.is_last) return 1'b0;
    scan(16'h0000, pos);            // implied terminator
    res.parsed_value   = ovf_f ? (neg ? S64_MIN : S64_MAX) : (neg ? -acc : acc);
    res.overflow       = ovf_f;
    res.consumed_count = dig_f ? COUNT_W'(end_pos) : '0;
    restart();
    return 1'b1;
  endfunction

  initial restart();

  // ------------------------------------------------------------------
  // Monitor: tracks radix writes, predicts on each unit transfer and
  // checks each result transfer against the oldest pending parse.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) base_reg = cfg_data;
      if (unit_valid && !unit_stall) begin
        if (parse_unit(unit_data, predicted)) begin
          key = answer_key.pop_front();
          pending_parses.push_back(key.on ? key.r : predicted);
        end
      end
      if (result_valid && !result_stall) begin
        if (pending_parses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value %0d ovf %0b count %0d",
                     result_data.parsed_value, result_data.overflow,
                     result_data.consumed_count);
        end else begin
          want = pending_parses.pop_front();
          if (result_data.parsed_value !== want.parsed_value ||
              result_data.overflow !== want.overflow ||
              result_data.consumed_count !== want.consumed_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp value %0d ovf %0b count %0d, got value %0d ovf %0b count %0d",
                       want.parsed_value, want.overflow, want.consumed_count,
                       result_data.parsed_value, result_data.overflow,
                       result_data.consumed_count);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result-side backpressure: random stall bursts of random length
  initial begin
    forever begin
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // One unit transfer, with an occasional idle burst ahead of it
  task automatic send_unit(input logic [15:0] cu, input bit last);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      unit_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    unit_valid <= 1'b1;
    unit_data  <= '{code_unit: cu, is_last: last};
    do @(posedge clk); while (unit_stall);
  endtask

  task automatic send_string(input units_t s);
    for (int i = 0; i < s.size(); i++) send_unit(s[i], i == s.size() - 1);
  endtask

  // Wait until every owed result has come out, plus the result latency
  task automatic settle();
    unit_valid <= 1'b0;
    @(posedge clk);
    while (pending_parses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Radix writes happen only with the block idle
  task automatic set_radix(input logic [BASE_W-1:0] b);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= b;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  initial begin
    units_t            s;
    dir_row_t          row;
    answer_t           ans;
    byte               ch;
    logic [BASE_W-1:0] b;
    int                r, top, nd, dv, style, core, rand_units;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int k = 0; k < N_DIR; k++) begin
      row = dir_rows[k];
      if (row.base >= 0) set_radix(BASE_W'(row.base));
      s = {};
      repeat (row.pad_len) s.push_back(row.pad_unit);
      for (int i = 0; i < row.text.len(); i++) begin
        ch = row.text[i];
        case (ch)
          "_":     s.push_back(16'h3000);
          "%":     s.push_back(16'h2000);
          "|":     s.push_back(16'hFFFF);
          "$":     s.push_back(16'h0000);
          default: s.push_back({8'h00, ch});
        endcase
      end
      ans.on = row.typed;
      ans.r  = '{parsed_value: row.val, overflow: row.ovf,
                 consumed_count: COUNT_W'(row.cnt)};
      answer_key.push_back(ans);
      send_string(s);
    end

    // random strings, in phases of one radix each
    rand_units = 0;
    while (rand_units < RAND_UNITS) begin
      case ($urandom_range(0, 7))
        0:       b = BASE_AUTO;
        1:       b = BASE_DEC;
        2:       b = BASE_HEX;
        3:       b = BASE_OCT;
        4:       b = 6'd2;
        5:       b = 6'd36;
        6:       b = 6'd63;
        default: b = BASE_W'($urandom_range(0, 63));
      endcase
      set_radix(b);
      repeat ($urandom_range(6, 20)) begin
        s = {};
        style = 2;
        case ($urandom_range(0, 9))
          0: begin
            // raw noise over the whole unit range
            repeat ($urandom_range(1, 6)) s.push_back(16'($urandom));
          end
          1: begin
            // broken: blanks, sign and/or prefix with no digit behind them
            if ($urandom_range(0, 1)) s.push_back(blank_units[$urandom_range(0, 20)]);
            if ($urandom_range(0, 1)) s.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            if ($urandom_range(0, 1)) begin
              s.push_back(CH_ZERO);
              s.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
            end
            s.push_back(16'($urandom_range(16'h0080, 16'hFFFF)));
          end
          default: begin
            // well-formed number with random content
            repeat ($urandom_range(0, 3)) s.push_back(blank_units[$urandom_range(0, 20)]);
            case ($urandom_range(0, 2))
              1: s.push_back(CH_PLUS);
              2: s.push_back(CH_MINUS);
              default: ;
            endcase
            r = int'(b);
            if (b == BASE_AUTO) begin
              style = $urandom_range(0, 2);
              if (style == 0) begin
                s.push_back(CH_ZERO);
                s.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
                r = 16;
              end else if (style == 1) begin
                s.push_back(CH_ZERO);
                r = 8;
              end else begin
                r = 10;
              end
            end else if (b == BASE_HEX && $urandom_range(0, 1)) begin
              s.push_back(CH_ZERO);
              s.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
            end
            top = (r > 36) ? 36 : r;
            nd = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 12);
            for (int i = 0; i < nd; i++) begin
              dv = $urandom_range(0, top - 1);
              // auto radix, decimal style: a leading 0 would switch to octal
              if (b == BASE_AUTO && style == 2 && i == 0 && dv == 0) dv = 1;
              s.push_back(char_of(dv, $urandom_range(0, 1)));
            end
            if (top < 36 && $urandom_range(0, 5) == 0) begin
              s.push_back(char_of($urandom_range(top, 35), $urandom_range(0, 1)));
              s.push_back(char_of($urandom_range(0, top - 1), 1'b0));
            end
          end
        endcase
        core = s.size();
        // trailing units, not counted in rand_units
        repeat ($urandom_range(0, 2)) s.push_back(16'($urandom_range(0, 16'h007F)));
        ans.on = 1'b0;
        ans.r  = '0;
        answer_key.push_back(ans);
        send_string(s);
        rand_units += core;
        quiet = (rand_units > RAND_UNITS - 300);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_parses.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- utf16_string_to_integer_parser_core.f -----
src/u16p_pkg.sv
src/u16p_step.sv
src/utf16_string_to_integer_parser_core.sv
tb/utf16_string_to_integer_parser_core_tb.sv
